// File: hw/rtl/bsc_pkg.sv
// Package for the barometric sensor compensation block: types, constants,
// and the calibration struct. No dependencies.
package bsc_pkg;

   localparam int DivWidth = 32;

   localparam logic [31:0] B6_OFFSET   = 32'd4000;
   localparam logic [31:0] B4_OFFSET   = 32'd32768;
   localparam logic [31:0] B7_SCALE    = 32'd50000;
   localparam logic [31:0] P_C1        = 32'd3038;
   localparam logic [31:0] P_C2        = 32'hFFFF_E343; // -7357
   localparam logic [31:0] P_C3        = 32'd3791;

   localparam logic [2:0] REG_AC1_AC2 = 3'd0;
   localparam logic [2:0] REG_AC3_AC4 = 3'd1;
   localparam logic [2:0] REG_AC5_AC6 = 3'd2;
   localparam logic [2:0] REG_B1_B2   = 3'd3;
   localparam logic [2:0] REG_MC_MD   = 3'd4;
   localparam logic [2:0] REG_OSS     = 3'd5;

   typedef struct packed {
      logic [31:0] ac1_ac2;
      logic [31:0] ac3_ac4;
      logic [31:0] ac5_ac6;
      logic [31:0] b1_b2;
      logic [31:0] mc_md;
      logic [1:0]  oss;
   } cal_type;

   function automatic logic [31:0] sx16(input logic [15:0] x);
      sx16 = {{16{x[15]}}, x};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
      asr = 32'($signed(v) >>> s);
   endfunction

endpackage

// File: hw/rtl/baro_sensor_compensation_top.sv
// Barometric sensor compensation. One beat in per cycle while not stalled, one
// result beat per input: 2 stages plus a 32-stage pipelined divider in the
// temperature half, then 5 stages, a 32-stage divider and 3 stages in the
// pressure half. The whole pipeline stalls as one unit when rsp_stall is high
// and a result is waiting; calibration is written through the csr_ APB port, and
// the user must write it only while the pipeline is empty; the block does not enforce this.
// Depends on bsc_pkg, bsc_csr, bsc_temp, bsc_press.
module baro_sensor_compensation_top
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_raw_temperature,
   input  logic [23:0] req_raw_pressure,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_temperature_tenths,
   output logic [31:0] rsp_pressure_pa,
   output logic        rsp_div_error
);
   cal_type     cal;
   logic        advance;
   logic        t_vld, t_err, p_vld, p_err;
   logic [31:0] t_b5, p_p;
   logic [15:0] t_t, p_t;
   logic [23:0] t_up;

   // pipeline moves unless the output beat is held
   assign advance   = !(p_vld && rsp_stall);
   assign req_stall = !advance;

   bsc_csr u_csr (
      .clock(clock), .reset(reset), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready), .cal(cal)
   );

   bsc_temp u_temp (
      .clock(clock), .reset(reset), .advance(advance), .cal(cal),
      .in_valid(req_valid), .in_ut(req_raw_temperature), .in_up(req_raw_pressure),
      .out_valid(t_vld), .out_b5(t_b5), .out_t(t_t), .out_err(t_err), .out_up(t_up)
   );

   bsc_press u_press (
      .clock(clock), .reset(reset), .advance(advance), .cal(cal),
      .in_valid(t_vld), .in_b5(t_b5), .in_t(t_t), .in_err(t_err), .in_up(t_up),
      .out_valid(p_vld), .out_t(p_t), .out_p(p_p), .out_err(p_err)
   );

   assign rsp_valid              = p_vld;
   assign rsp_temperature_tenths = p_t;
   assign rsp_pressure_pa        = p_p;
   assign rsp_div_error          = p_err;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_error |-> rsp_pressure_pa == 32'd0)
      else $error("pressure not zero on divide error");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pressure_pa))
      else $error("held result changed");
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");
endmodule

// File: hw/rtl/bsc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bsc_pkg. Carries a sideband word alongside each beat.
module bsc_div
   import bsc_pkg::*;
#(
   parameter int SideWidth = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [DivWidth-1:0]  in_num,
   input  logic [DivWidth-1:0]  in_den,
   input  logic [SideWidth-1:0] in_side,
   output logic                 out_valid,
   output logic [DivWidth-1:0]  out_quo,
   output logic [SideWidth-1:0] out_side
);
   // entry i holds the output of stage i
   logic                  vld_ff  [DivWidth];
   logic [DivWidth-1:0]   rem_ff  [DivWidth];
   logic [DivWidth-1:0]   num_ff  [DivWidth];
   logic [DivWidth-1:0]   den_ff  [DivWidth];
   logic [SideWidth-1:0]  side_ff [DivWidth];

   for (genvar i = 0; i < DivWidth; i++) begin : g_stage
      logic                 src_vld;
      logic [DivWidth-1:0]  src_rem;
      logic [DivWidth-1:0]  src_num;
      logic [DivWidth-1:0]  src_den;
      logic [SideWidth-1:0] src_side;
      logic [DivWidth:0]    trial_in;
      logic [DivWidth:0]    diff_in;
      logic [DivWidth-1:0]  rem_in;
      logic [DivWidth-1:0]  num_in;

      if (i == 0) begin : g_head
         assign src_vld  = in_valid;
         assign src_rem  = '0;
         assign src_num  = in_num;
         assign src_den  = in_den;
         assign src_side = in_side;
      end else begin : g_tail
         assign src_vld  = vld_ff[i-1];
         assign src_rem  = rem_ff[i-1];
         assign src_num  = num_ff[i-1];
         assign src_den  = den_ff[i-1];
         assign src_side = side_ff[i-1];
      end

      always_comb begin
         trial_in = {src_rem, src_num[DivWidth-1]};
         diff_in  = trial_in - {1'b0, src_den};
         if (!diff_in[DivWidth]) begin
            rem_in = diff_in[DivWidth-1:0];
            num_in = {src_num[DivWidth-2:0], 1'b1};
         end else begin
            rem_in = trial_in[DivWidth-1:0];
            num_in = {src_num[DivWidth-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= src_vld;
         end
         if (advance) begin
            rem_ff[i]  <= rem_in;
            num_ff[i]  <= num_in;
            den_ff[i]  <= src_den;
            side_ff[i] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[DivWidth-1];
   assign out_quo   = num_ff[DivWidth-1];
   assign out_side  = side_ff[DivWidth-1];
endmodule

// File: hw/rtl/bsc_csr.sv
// APB-style register file for calibration words and oversampling.
// Depends on bsc_pkg.
module bsc_csr
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cal_type     cal
);
   cal_type     cal_ff;
   logic [2:0]  idx;

   assign idx = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cal = cal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '{ac1_ac2: 32'd0, ac3_ac4: 32'd0, ac5_ac6: 32'd0, b1_b2: 32'd0,
                     mc_md: 32'd0, oss: 2'd3};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            REG_AC1_AC2: cal_ff.ac1_ac2 <= csr_pwdata;
            REG_AC3_AC4: cal_ff.ac3_ac4 <= csr_pwdata;
            REG_AC5_AC6: cal_ff.ac5_ac6 <= csr_pwdata;
            REG_B1_B2:   cal_ff.b1_b2   <= csr_pwdata;
            REG_MC_MD:   cal_ff.mc_md   <= csr_pwdata;
            REG_OSS:     cal_ff.oss     <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_AC1_AC2: csr_prdata = cal_ff.ac1_ac2;
         REG_AC3_AC4: csr_prdata = cal_ff.ac3_ac4;
         REG_AC5_AC6: csr_prdata = cal_ff.ac5_ac6;
         REG_B1_B2:   csr_prdata = cal_ff.b1_b2;
         REG_MC_MD:   csr_prdata = cal_ff.mc_md;
         REG_OSS:     csr_prdata = {30'd0, cal_ff.oss};
         default:     csr_prdata = '0;
      endcase
   end
endmodule

// File: hw/rtl/bsc_temp.sv
// Temperature half: x1 product, signed divide mc*2048/(x1+md), b5 and t.
// Depends on bsc_pkg and bsc_div.
module bsc_temp
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  cal_type     cal,
   input  logic        in_valid,
   input  logic [15:0] in_ut,
   input  logic [23:0] in_up,
   output logic        out_valid,
   output logic [31:0] out_b5,
   output logic [15:0] out_t,
   output logic        out_err,
   output logic [23:0] out_up
);
   localparam int SideW = 32 + 1 + 1 + 1 + 24;

   logic        s1_vld_ff, s2_vld_ff;
   logic [31:0] s1_diff_ff, s1_ac5_ff;
   logic [23:0] s1_up_ff, s2_up_ff;
   logic [31:0] s2_x1_ff, s2_den_ff;
   logic [31:0] x1_in, den_in, num_in, mag_num, mag_den;
   logic [SideW-1:0] side_in, side_out;
   logic        dvld, neg_in;
   logic [31:0] quo, x1o, x2, b5, t_full;
   logic        nego, zo;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
      end
      if (advance) begin
         s1_diff_ff <= {16'd0, in_ut} - {16'd0, cal.ac5_ac6[15:0]};
         s1_ac5_ff  <= {16'd0, cal.ac5_ac6[31:16]};
         s1_up_ff   <= in_up;
         s2_x1_ff   <= x1_in;
         s2_den_ff  <= x1_in + sx16(cal.mc_md[15:0]);
         s2_up_ff   <= s1_up_ff;
      end
   end

   assign x1_in  = asr(s1_diff_ff * s1_ac5_ff, 5'd15);
   assign den_in = s2_den_ff;
   assign num_in = sx16(cal.mc_md[31:16]) << 11;
   assign neg_in = num_in[31] ^ den_in[31];
   assign mag_num = num_in[31] ? 32'd0 - num_in : num_in;
   assign mag_den = den_in[31] ? 32'd0 - den_in : den_in;
   assign side_in = {s2_x1_ff, neg_in, (den_in == 32'd0), 1'b0, s2_up_ff};

   bsc_div #(.SideWidth(SideW)) u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(s2_vld_ff), .in_num(mag_num), .in_den(mag_den), .in_side(side_in),
      .out_valid(dvld), .out_quo(quo), .out_side(side_out)
   );

   always_comb begin
      x1o  = side_out[SideW-1 -: 32];
      nego = side_out[26];
      zo   = side_out[25];
      x2   = zo ? 32'd0 : (nego ? 32'd0 - quo : quo);
      b5   = x1o + x2;
   end

   assign t_full    = asr(b5 + 32'd8, 5'd4);
   assign out_valid = dvld;
   assign out_b5    = b5;
   assign out_t     = t_full[15:0];
   assign out_err   = zo | side_out[24];
   assign out_up    = side_out[23:0];
endmodule

// File: hw/rtl/bsc_press.sv
// Pressure half: b6..b7 products in stages, unsigned divide b7/b4,
// final polynomial correction. Depends on bsc_pkg and bsc_div.
module bsc_press
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  cal_type     cal,
   input  logic        in_valid,
   input  logic [31:0] in_b5,
   input  logic [15:0] in_t,
   input  logic        in_err,
   input  logic [23:0] in_up,
   output logic        out_valid,
   output logic [15:0] out_t,
   output logic [31:0] out_p,
   output logic        out_err
);
   localparam int SideW = 16 + 1 + 1;
   logic [4:0] oss5;
   assign oss5 = {3'd0, cal.oss};

   // stage A: b6, up shift
   logic        a_vld_ff; logic [31:0] a_b6_ff, a_up_ff; logic [15:0] a_t_ff; logic a_err_ff;
   // stage B: sq, ac2*b6, ac3*b6
   logic        b_vld_ff; logic [31:0] b_sq_ff, b_x2_ff, b_x1c_ff, b_up_ff;
   logic [15:0] b_t_ff; logic b_err_ff;
   // stage C: b2*sq, b1*sq
   logic        c_vld_ff; logic [31:0] c_x3_ff, c_x3b_ff, c_up_ff;
   logic [15:0] c_t_ff; logic c_err_ff;
   // stage D: b3, b4
   logic        d_vld_ff; logic [31:0] d_b3_ff, d_b4_ff, d_up_ff;
   logic [15:0] d_t_ff; logic d_err_ff;
   // stage E: b7
   logic        e_vld_ff; logic [31:0] e_b7_ff, e_b4_ff;
   logic [15:0] e_t_ff; logic e_err_ff;

   logic [31:0] sum_in, b3_in, b4sum_in;
   always_comb begin
      sum_in   = ((sx16(cal.ac1_ac2[31:16]) << 2) + c_x3_ff) << oss5;
      sum_in   = sum_in + 32'd2;
      // signed divide by 4 truncates toward zero
      b3_in    = asr(sum_in + (sum_in[31] ? 32'd3 : 32'd0), 5'd2);
      b4sum_in = asr(c_x3b_ff + 32'd2, 5'd2) + B4_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0; b_vld_ff <= 1'b0; c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0; e_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= in_valid; b_vld_ff <= a_vld_ff; c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff; e_vld_ff <= d_vld_ff;
      end
      if (advance) begin
         a_b6_ff  <= in_b5 - B6_OFFSET;
         a_up_ff  <= {8'd0, in_up} >> (5'd8 - oss5);
         a_t_ff   <= in_t;  a_err_ff <= in_err;
         b_sq_ff  <= asr(a_b6_ff * a_b6_ff, 5'd12);
         b_x2_ff  <= asr(sx16(cal.ac1_ac2[15:0]) * a_b6_ff, 5'd11);
         b_x1c_ff <= asr(sx16(cal.ac3_ac4[31:16]) * a_b6_ff, 5'd13);
         b_up_ff  <= a_up_ff; b_t_ff <= a_t_ff; b_err_ff <= a_err_ff;
         c_x3_ff  <= asr(sx16(cal.b1_b2[15:0]) * b_sq_ff, 5'd11) + b_x2_ff;
         c_x3b_ff <= b_x1c_ff + asr(sx16(cal.b1_b2[31:16]) * b_sq_ff, 5'd16);
         c_up_ff  <= b_up_ff; c_t_ff <= b_t_ff; c_err_ff <= b_err_ff;
         d_b3_ff  <= b3_in;
         d_b4_ff  <= ({16'd0, cal.ac3_ac4[15:0]} * b4sum_in) >> 15;
         d_up_ff  <= c_up_ff; d_t_ff <= c_t_ff; d_err_ff <= c_err_ff;
         e_b7_ff  <= (d_up_ff - d_b3_ff) * (B7_SCALE >> oss5);
         e_b4_ff  <= d_b4_ff;
         e_t_ff   <= d_t_ff;
         e_err_ff <= d_err_ff | (d_b4_ff == 32'd0);
      end
   end

   // small b7 -> (b7*2)/b4 ; large -> (b7/b4)*2
   logic        big_in;
   logic [31:0] num_in;
   logic [SideW-1:0] side_out;
   logic        dvld;
   logic [31:0] quo;
   assign big_in = e_b7_ff[31];
   assign num_in = big_in ? e_b7_ff : (e_b7_ff << 1);

   bsc_div #(.SideWidth(SideW)) u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(e_vld_ff), .in_num(num_in), .in_den(e_b4_ff),
      .in_side({e_t_ff, e_err_ff, big_in}),
      .out_valid(dvld), .out_quo(quo), .out_side(side_out)
   );

   // stage F: p, p>>8 squared, c2*p
   logic        f_vld_ff; logic [31:0] f_p_ff, f_sq_ff, f_x2_ff;
   logic [15:0] f_t_ff; logic f_err_ff;
   // stage G: 3038 term
   logic        g_vld_ff; logic [31:0] g_p_ff, g_x1_ff, g_x2_ff;
   logic [15:0] g_t_ff; logic g_err_ff;
   // output stage
   logic        h_vld_ff; logic [31:0] h_p_ff; logic [15:0] h_t_ff; logic h_err_ff;

   logic [31:0] p_in, ps_in;
   assign p_in  = side_out[0] ? (quo << 1) : quo;
   assign ps_in = asr(p_in, 5'd8);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0; g_vld_ff <= 1'b0; h_vld_ff <= 1'b0;
      end else if (advance) begin
         f_vld_ff <= dvld; g_vld_ff <= f_vld_ff; h_vld_ff <= g_vld_ff;
      end
      if (advance) begin
         f_p_ff   <= p_in;
         f_sq_ff  <= ps_in * ps_in;
         f_x2_ff  <= asr(P_C2 * p_in, 5'd16);
         f_t_ff   <= side_out[SideW-1 -: 16];
         f_err_ff <= side_out[1];
         g_x1_ff  <= asr(f_sq_ff * P_C1, 5'd16);
         g_p_ff   <= f_p_ff; g_x2_ff <= f_x2_ff; g_t_ff <= f_t_ff; g_err_ff <= f_err_ff;
         h_p_ff   <= g_err_ff ? 32'd0
                     : g_p_ff + asr(g_x1_ff + g_x2_ff + P_C3, 5'd4);
         h_t_ff   <= g_t_ff; h_err_ff <= g_err_ff;
      end
   end

   assign out_valid = h_vld_ff;
   assign out_t     = h_t_ff;
   assign out_p     = h_p_ff;
   assign out_err   = h_err_ff;
endmodule

// File: tb/sv/baro_sensor_compensation_top_tb.sv
// Testbench for baro_sensor_compensation_top: drives raw reading beats, predicts each
// compensated result in a local model and checks every result beat in order.
// Depends on bsc_pkg and the baro_sensor_compensation_top RTL.
`timescale 1ns / 100ps

module baro_sensor_compensation_top_tb
   import bsc_pkg::*;
();

   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN_WAIT = 120;

   typedef struct packed {
      logic [15:0] temp;
      logic [31:0] press;
      logic        err;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_raw_temperature = '0;
   logic [23:0] req_raw_pressure = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_temperature_tenths;
   logic [31:0] rsp_pressure_pa;
   logic        rsp_div_error;

   logic [31:0] cal_shadow [6];
   reading_type expected_readings[$];
   int          error_count = 0;
   int          idle_count = 0;
   int          hold_request = 0;

   baro_sensor_compensation_top uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------- reference arithmetic ----------------
   function automatic logic [31:0] sar(input logic [31:0] v, input int s);
      logic signed [31:0] sv;
      sv = v;
      return sv >>> s;
   endfunction

   function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic logic [31:0] ext16(input logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

   function automatic reading_type compensate(input logic [15:0] ut_raw,
                                              input logic [23:0] pr_raw);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, den;
      int          oss;
      reading_type r;
      ac1 = ext16(cal_shadow[REG_AC1_AC2][31:16]);
      ac2 = ext16(cal_shadow[REG_AC1_AC2][15:0]);
      ac3 = ext16(cal_shadow[REG_AC3_AC4][31:16]);
      ac4 = {16'h0, cal_shadow[REG_AC3_AC4][15:0]};
      ac5 = {16'h0, cal_shadow[REG_AC5_AC6][31:16]};
      ac6 = {16'h0, cal_shadow[REG_AC5_AC6][15:0]};
      b1  = ext16(cal_shadow[REG_B1_B2][31:16]);
      b2  = ext16(cal_shadow[REG_B1_B2][15:0]);
      mc  = ext16(cal_shadow[REG_MC_MD][31:16]);
      md  = ext16(cal_shadow[REG_MC_MD][15:0]);
      oss = int'(cal_shadow[REG_OSS][1:0]);
      ut  = {16'h0, ut_raw};
      up  = {8'h0, pr_raw} >> (8 - oss);
      r.err = 1'b0;

      x1  = sar((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 32'd0) begin
         r.err = 1'b1;
         x2 = 32'd0;
      end else begin
         x2 = div_trunc(mc * 32'd2048, den);
      end
      b5 = x1 + x2;
      x3 = sar(b5 + 32'd8, 4);
      r.temp = x3[15:0];

      b6 = b5 - 32'd4000;
      sq = sar(b6 * b6, 12);
      x1 = sar(b2 * sq, 11);
      x2 = sar(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = div_trunc(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);

      x1 = sar(ac3 * b6, 13);
      x2 = sar(b1 * sq, 16);
      x3 = sar(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      b7 = (up - b3) * (32'd50000 >> oss);

      if (b4 == 32'd0) r.err = 1'b1;
      if (r.err) begin
         p = 32'd0;
      end else begin
         if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
         else p = (b7 / b4) * 32'd2;
         x1 = sar(p, 8) * sar(p, 8);
         x1 = sar(x1 * 32'd3038, 16);
         x2 = sar(32'hFFFF_E343 * p, 16);
         p  = p + sar(x1 + x2 + 32'd3791, 4);
      end
      r.press = p;
      return r;
   endfunction

   // ---------------- monitors ----------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // handshake signals are stable between the falling and the next rising edge
   always @(negedge clock) begin
      reading_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_readings.push_back(compensate(req_raw_temperature, req_raw_pressure));
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("unexpected beat", rsp_pressure_pa, 32'h0);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_temperature_tenths !== want.temp)
                  report_mismatch("temperature", {16'h0, rsp_temperature_tenths},
                                  {16'h0, want.temp});
               if (rsp_pressure_pa !== want.press)
                  report_mismatch("pressure", rsp_pressure_pa, want.press);
               if (rsp_div_error !== want.err)
                  report_mismatch("div_error", {31'h0, rsp_div_error}, {31'h0, want.err});
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count = 0;
         else idle_count++;
      end
   end

   always @(posedge clock) begin
      if (idle_count >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: stall style is redrawn when its period runs out; a hold request overrides it
   always @(posedge clock) begin
      static int style = 0;
      static int style_left = 0;
      static int hold_left = 0;
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (style_left == 0) begin
         style = $urandom_range(0, 2);
         style_left = 64;
      end
      style_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // ---------------- drivers ----------------
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cal_shadow[idx] = (idx == REG_OSS) ? (val & 32'd3) : val;
   endtask

   task automatic send_reading(input logic [15:0] ut, input logic [23:0] pr);
      logic taken;
      taken = 1'b0;
      req_valid           <= 1'b1;
      req_raw_temperature <= ut;
      req_raw_pressure    <= pr;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
   endtask

   task automatic pause_cycles(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic load_calibration(input logic [31:0] v0, input logic [31:0] v1,
                                   input logic [31:0] v2, input logic [31:0] v3,
                                   input logic [31:0] v4, input logic [1:0] oss);
      wait_drained();
      csr_write(REG_AC1_AC2, v0);
      csr_write(REG_AC3_AC4, v1);
      csr_write(REG_AC5_AC6, v2);
      csr_write(REG_B1_B2, v3);
      csr_write(REG_MC_MD, v4);
      csr_write(REG_OSS, {30'h0, oss});
   endtask

   // datasheet-like coefficients with some jitter
   task automatic load_typical(input logic [1:0] oss);
      logic [15:0] j;
      j = 16'($urandom_range(0, 63));
      load_calibration({16'd408 + j, 16'hFFB8}, {16'hC7D1, 16'd32741 - j},
                       {16'd32757 - j, 16'd23153 + j}, {16'd6190, 16'd4},
                       {16'hDDE9, 16'd2868 + j}, oss);
   endtask

   task automatic load_any(input logic [1:0] oss);
      load_calibration($urandom, $urandom, $urandom, $urandom, $urandom, oss);
   endtask

   task automatic send_random_block(input int n, input bit typical, input bit gaps);
      int burst_left;
      burst_left = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
         if (typical)
            send_reading(16'($urandom_range(23000, 32000)),
                         24'($urandom_range(24'h500000, 24'hA00000)));
         else
            send_reading(16'($urandom), 24'($urandom));
         burst_left--;
         if (gaps && burst_left == 0) begin
            pause_cycles($urandom_range(1, 8));
            burst_left = $urandom_range(1, 30);
         end
      end
   endtask

   // ---------------- tests ----------------
   task automatic test_reference_point();
      load_calibration({16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741}, {16'd32757, 16'd23153},
                       {16'd6190, 16'd4}, {16'hDDE9, 16'd2868}, 2'd0);
      send_reading(16'd27898, {16'd23843, 8'h00});
      for (int o = 0; o < 4; o++) begin
         load_typical(o[1:0]);
         send_reading(16'd27898, 24'h5D2300);
         send_reading(16'd0, 24'h000000);
         send_reading(16'hFFFF, 24'hFFFFFF);
      end
   endtask

   task automatic test_zero_divisors();
      // ac5 = 0 and md = 0 make the temperature divisor zero
      load_calibration({16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741}, {16'd0, 16'd23153},
                       {16'd6190, 16'd4}, {16'hDDE9, 16'd0}, 2'd1);
      send_reading(16'd27898, 24'h5D2300);
      send_reading(16'hFFFF, 24'hFFFFFF);
      // ac4 = 0 forces B4 to zero
      load_calibration({16'd408, 16'hFFB8}, {16'hC7D1, 16'd0}, {16'd32757, 16'd23153},
                       {16'd6190, 16'd4}, {16'hDDE9, 16'd2868}, 2'd2);
      send_reading(16'd27898, 24'h5D2300);
      send_reading(16'd0, 24'h000000);
   endtask

   task automatic test_extremes();
      load_calibration('1, '1, '1, '1, '1, 2'd3);
      send_reading(16'd0, 24'h000000);
      send_reading(16'hFFFF, 24'hFFFFFF);
      send_reading(16'h8000, 24'h800000);
      load_calibration(32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_0000,
                       32'h8000_7FFF, 32'h7FFF_8000, 2'd0);
      send_reading(16'd0, 24'hFFFFFF);
      send_reading(16'hFFFF, 24'h000000);
      load_calibration(32'h7FFF_7FFF, 32'h7FFF_0001, 32'h0001_FFFF,
                       32'h7FFF_8000, 32'h8000_7FFF, 2'd3);
      send_reading(16'h7FFF, 24'h7FFFFF);
      send_reading(16'h0001, 24'h000001);
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < 8; ph++) begin
         if (ph % 3 == 2) load_any(2'($urandom_range(0, 3)));
         else load_typical(ph[1:0]);
         send_random_block(140, ph % 3 != 2, 1'b1);
         if (ph % 4 == 3) send_random_block(20, 1'b0, 1'b0);
      end
   endtask

   task automatic test_backpressure();
      load_typical(2'd3);
      hold_request = 400;
      send_random_block(150, 1'b1, 1'b0);
   endtask

   task automatic test_drain_pause();
      load_typical(2'd1);
      send_random_block(40, 1'b1, 1'b1);
      wait_drained();
      send_random_block(40, 1'b0, 1'b1);
   endtask

   initial begin
      cal_shadow = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd3};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reference_point();
      test_zero_divisors();
      test_extremes();
      test_random_settings();
      test_backpressure();
      test_drain_pause();
      wait_drained();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
